FILE: design/hlpd_pkg.sv
// ----------------------------------------------------------------------------
// hlpd_pkg
// Shared types, constants and helper functions for the length packet deframer.
// ----------------------------------------------------------------------------
package hlpd_pkg;

    localparam int BODY_DEPTH = 64;
    localparam int ADDR_W     = $clog2(BODY_DEPTH);
    localparam int LEN_W      = 6;
    localparam int MAXLEN_W   = 7;
    localparam int CFG_ADDR_W = 3;
    localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = 7'd32;

    typedef enum logic [2:0] {
        ST_DATA     = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_BAD_HEX  = 3'd2,
        ST_TOO_LONG = 3'd3,
        ST_STOP_BAD = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_HUNT,
        S_HEX_HI,
        S_HEX_LO,
        S_BODY,
        S_STOP,
        S_READ,
        S_LOAD
    } state_t;

    typedef enum logic [1:0] {
        MK_HOLD,
        MK_INC,
        MK_CLR,
        MK_RESTART
    } mark_op_t;

    typedef struct packed {
        mark_op_t mark_op;
        logic     load_hi;
        logic     load_len;
        logic     body_wr;
        logic     rd_start;
        logic     rd_issue;
        logic     out_load;
        status_t  out_status;
    } hlpd_cmd_t;

    typedef struct packed {
        logic start_match;
        logic marker_end;
        logic hex_ok;
        logic len_bad;
        logic new_len_zero;
        logic len_zero;
        logic body_done;
        logic stop_match;
        logic stop_end;
        logic out_free;
        logic emit_last;
    } hlpd_stat_t;

    // Returns 0 to 15 for a hex digit and 16 for any other byte.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = 5'(c - 8'h30);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = 5'(c - 8'h37);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            v = 5'(c - 8'h57);
        end
        else
        begin
            v = 5'd16;
        end
        return v;
    endfunction

    function automatic logic [7:0] start_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h41;
            2'd1:    c = 8'h53;
            2'd2:    c = 8'h4B;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] stop_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h45;
            2'd1:    c = 8'h4E;
            2'd2:    c = 8'h44;
            default: c = 8'h0A;
        endcase
        return c;
    endfunction

endpackage

FILE: design/hlpd_ctrl.sv
// ----------------------------------------------------------------------------
// hlpd_ctrl
// Frame parsing state machine; drives the datapath through command signals.
// ----------------------------------------------------------------------------
module hlpd_ctrl
    import hlpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  hlpd_stat_t stat,
    output hlpd_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   acc;

    assign s_tready = (state_reg != S_READ) && (state_reg != S_LOAD) && stat.out_free;
    assign acc      = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_HUNT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.mark_op    = MK_HOLD;
        cmd.out_status = ST_DATA;
        case (state_reg)
            S_HUNT:
            begin
                if (acc)
                begin
                    if (stat.start_match)
                    begin
                        if (stat.marker_end)
                        begin
                            cmd.mark_op = MK_CLR;
                            state_next  = S_HEX_HI;
                        end
                        else
                        begin
                            cmd.mark_op = MK_INC;
                        end
                    end
                    else
                    begin
                        cmd.mark_op = MK_RESTART;
                    end
                end
            end
            S_HEX_HI:
            begin
                if (acc)
                begin
                    if (stat.hex_ok)
                    begin
                        cmd.load_hi = 1'b1;
                        state_next  = S_HEX_LO;
                    end
                    else
                    begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = ST_BAD_HEX;
                        cmd.mark_op    = MK_RESTART;
                        state_next     = S_HUNT;
                    end
                end
            end
            S_HEX_LO:
            begin
                if (acc)
                begin
                    if (!stat.hex_ok)
                    begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = ST_BAD_HEX;
                        cmd.mark_op    = MK_RESTART;
                        state_next     = S_HUNT;
                    end
                    else if (stat.len_bad)
                    begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = ST_TOO_LONG;
                        cmd.mark_op    = MK_RESTART;
                        state_next     = S_HUNT;
                    end
                    else
                    begin
                        cmd.load_len = 1'b1;
                        cmd.mark_op  = MK_CLR;
                        state_next   = stat.new_len_zero ? S_STOP : S_BODY;
                    end
                end
            end
            S_BODY:
            begin
                if (acc)
                begin
                    cmd.body_wr = 1'b1;
                    if (stat.body_done)
                    begin
                        cmd.mark_op = MK_CLR;
                        state_next  = S_STOP;
                    end
                end
            end
            S_STOP:
            begin
                if (acc)
                begin
                    if (!stat.stop_match)
                    begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = ST_STOP_BAD;
                        cmd.mark_op    = MK_RESTART;
                        state_next     = S_HUNT;
                    end
                    else if (!stat.stop_end)
                    begin
                        cmd.mark_op = MK_INC;
                    end
                    else if (stat.len_zero)
                    begin
                        cmd.mark_op    = MK_CLR;
                        cmd.out_load   = 1'b1;
                        cmd.out_status = ST_EMPTY;
                        state_next     = S_HUNT;
                    end
                    else
                    begin
                        cmd.mark_op  = MK_CLR;
                        cmd.rd_start = 1'b1;
                        state_next   = S_READ;
                    end
                end
            end
            S_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_LOAD;
            end
            S_LOAD:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = ST_DATA;
                    state_next     = stat.emit_last ? S_HUNT : S_READ;
                end
            end
            default:
            begin
                state_next = S_HUNT;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_read_then_load: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |=> state_reg == S_LOAD)
        else $error("memory read was not followed by the load step");

    a_burst_only_data: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD && cmd.out_load) |-> cmd.out_status == ST_DATA)
        else $error("burst loaded a non-data result");

    a_body_needs_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HEX_LO && state_next == S_BODY) |-> !stat.new_len_zero)
        else $error("body phase entered with a zero length");
`endif

endmodule

FILE: design/hlpd_dp.sv
// ----------------------------------------------------------------------------
// hlpd_dp
// Datapath: marker and length registers, body store, limit register and the
// output register.
// ----------------------------------------------------------------------------
module hlpd_dp
    import hlpd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            rx_byte,
    input  hlpd_cmd_t             cmd,
    output hlpd_stat_t            stat,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,
    output logic                  m_tlast,
    output logic [2:0]            m_tuser,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata
);

    logic [1:0]          marker_reg;
    logic [3:0]          high_reg;
    logic [ADDR_W-1:0]   len_reg;
    logic [ADDR_W-1:0]   count_reg;
    logic [ADDR_W-1:0]   rd_reg;
    logic [MAXLEN_W-1:0] max_reg;
    logic                m_valid_reg;
    logic [7:0]          rdata_reg;
    logic [7:0]          out_data_reg;
    logic                out_last_reg;
    status_t             out_status_reg;
    logic [LEN_W-1:0]    out_len_reg;
    logic [7:0]          body_mem [BODY_DEPTH];

    logic [4:0]          hex_val;
    logic [7:0]          len8;
    logic [LEN_W-1:0]    len_sat;
    logic [ADDR_W:0]     count_inc;
    logic [ADDR_W:0]     rd_inc;
    logic                cfg_wr;
    logic [7:0]          out_data_next;
    logic                out_last_next;
    logic [LEN_W-1:0]    out_len_next;

    assign hex_val   = hex_value(rx_byte);
    assign len8      = {high_reg, hex_val[3:0]};
    assign len_sat   = (len8 > 8'd63) ? 6'd63 : len8[LEN_W-1:0];
    assign count_inc = {1'b0, count_reg} + (ADDR_W+1)'(1);
    assign rd_inc    = {1'b0, rd_reg} + (ADDR_W+1)'(1);

    always_comb
    begin
        stat              = '0;
        stat.start_match  = (marker_reg != 2'd3) && (rx_byte == start_char(marker_reg));
        stat.marker_end   = (marker_reg == 2'd2);
        stat.hex_ok       = !hex_val[4];
        stat.len_bad      = (len8 >= {1'b0, max_reg}) || (len8 >= 8'(BODY_DEPTH));
        stat.new_len_zero = (len8 == 8'd0);
        stat.len_zero     = (len_reg == '0);
        stat.body_done    = (count_inc >= {1'b0, len_reg});
        stat.stop_match   = (rx_byte == stop_char(marker_reg));
        stat.stop_end     = (marker_reg == 2'd3);
        stat.out_free     = !m_valid_reg || m_tready;
        stat.emit_last    = (rd_inc == {1'b0, len_reg});
    end

    assign cfg_wr = psel && penable && pwrite && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : 32'(max_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_reg  <= 2'd0;
            high_reg    <= 4'd0;
            len_reg     <= '0;
            count_reg   <= '0;
            rd_reg      <= '0;
            max_reg     <= MAXLEN_RESET;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            case (cmd.mark_op)
                MK_INC:     marker_reg <= marker_reg + 2'd1;
                MK_CLR:     marker_reg <= 2'd0;
                MK_RESTART: marker_reg <= (rx_byte == start_char(2'd0)) ? 2'd1 : 2'd0;
                default:    marker_reg <= marker_reg;
            endcase
            if (cmd.load_hi)
            begin
                high_reg <= hex_val[3:0];
            end
            if (cmd.load_len)
            begin
                len_reg   <= len8[ADDR_W-1:0];
                count_reg <= '0;
            end
            else if (cmd.body_wr)
            begin
                count_reg <= count_inc[ADDR_W-1:0];
            end
            if (cmd.rd_start)
            begin
                rd_reg <= '0;
            end
            else if (cmd.out_load && cmd.out_status == ST_DATA)
            begin
                rd_reg <= rd_inc[ADDR_W-1:0];
            end
            if (cfg_wr)
            begin
                max_reg <= pwdata[MAXLEN_W-1:0];
            end
            if (cmd.out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.body_wr)
        begin
            body_mem[count_reg] <= rx_byte;
        end
        if (cmd.rd_issue)
        begin
            rdata_reg <= body_mem[rd_reg];
        end
    end

    always_comb
    begin
        out_data_next = 8'd0;
        out_last_next = 1'b1;
        out_len_next  = '0;
        case (cmd.out_status)
            ST_DATA:
            begin
                out_data_next = rdata_reg;
                out_last_next = stat.emit_last;
                out_len_next  = LEN_W'(len_reg);
            end
            ST_TOO_LONG:
            begin
                out_len_next = len_sat;
            end
            ST_STOP_BAD:
            begin
                out_len_next = LEN_W'(len_reg);
            end
            default:
            begin
                out_len_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg   <= out_data_next;
            out_last_reg   <= out_last_next;
            out_status_reg <= cmd.out_status;
            out_len_reg    <= out_len_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, out_len_reg, out_data_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_status_reg;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_valid_reg || m_tready))
        else $error("output register loaded while a result was still held");

    a_write_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.body_wr |-> (count_reg < len_reg))
        else $error("body write beyond the decoded length");

    a_read_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_issue |-> (rd_reg < len_reg))
        else $error("body read beyond the decoded length");
`endif

endmodule

FILE: design/hex_length_packet_deframer.sv
// ----------------------------------------------------------------------------
// hex_length_packet_deframer
// Receive-side parser for frames of the form ASK, two hex length digits, body
// bytes and the stop marker END plus newline.
// An error or empty-frame result is registered at the edge that accepts its
// input; a finished frame's first body byte is read from the body store in
// the read state, then loaded into the output register in the load state,
// which waits while the output register is held. Throughput: one input byte
// per cycle while the output register is empty or draining; a finished frame
// then emits its body bytes via registered body store reads, taking no input.
// Reset: asynchronous, active low; the block hunts for a start marker and the
// length limit returns to 32. The body store is not cleared.
// ----------------------------------------------------------------------------
module hex_length_packet_deframer
    import hlpd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // rx_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // data_byte[7:0], body_length[13:8]
    output logic                  m_tlast,   // is_last
    output logic [2:0]            m_tuser,   // status
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    hlpd_cmd_t  cmd;
    hlpd_stat_t stat;

    assign pready = 1'b1;

    hlpd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    hlpd_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_byte  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata)
    );

endmodule
